[rtl/mctq_pkg.sv]
// Shared constants, codes and widths of the multi-channel task queue.
package mctq_pkg;

  localparam int NUM_TASKS    = 16;
  localparam int NUM_CHANNELS = 8;
  localparam int TASK_W       = $clog2(NUM_TASKS);
  localparam int CHAN_W       = $clog2(NUM_CHANNELS);

  typedef logic [TASK_W-1:0] task_t;
  typedef logic [CHAN_W-1:0] chan_t;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_POP      = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ALREADY    = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_NOT_QUEUED = 2'd3
  } status_e;

endpackage

[rtl/mctq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mctq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/multi_channel_task_queue_unit.sv]
// Top level of the multi-channel task queue: channels as linked lists in RAM.
//
// A pool of task slots is shared by a set of channels; each channel is a FIFO
// kept as a doubly linked list. Successor links, predecessor links and the
// channel of each task live in three task RAMs; head and tail pointers live in
// two channel RAMs. Only the per-task queued flags and per-channel non-empty
// flags sit in flip-flops, so reset clears them at once and no clearing pass
// is needed. A request is taken when start_i is high and busy_o is low.
// Schedule, query, a pop of an empty channel and a remove of a task that is
// not queued need one RAM read, then the update; a successful pop or remove
// needs a second RAM read before the update, for the second list lookup (the
// head's links, or the head and tail of the removed task's channel). The
// result is shown for exactly one cycle with done_o, registered, in the cycle
// after the update; busy_o is already low in that cycle, so the next request
// can be taken while the result is on the ports. The receiver cannot hold
// results off: a result not taken in its cycle is lost to it.
module multi_channel_task_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mctq_pkg::op_e       opcode_i,
  input  mctq_pkg::task_t     task_index_i,
  input  mctq_pkg::chan_t     channel_index_i,
  output logic                done_o,
  output mctq_pkg::status_e   status_o,
  output mctq_pkg::task_t     task_out_o,
  output logic                is_queued_o,
  output mctq_pkg::chan_t     channel_out_o
);

  import mctq_pkg::*;

  // Sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;

  logic [1:0] state_q, state_d;

  // Request held for the whole operation
  op_e   op_q;
  task_t t_q;
  chan_t c_q;

  // Flags in flip-flops
  logic [NUM_TASKS-1:0]    queued_q, queued_d;
  logic [NUM_CHANNELS-1:0] nonempty_q, nonempty_d;

  // RAM ports
  task_t task_raddr;
  chan_t chan_raddr;
  chan_t tchan_rd;
  task_t tnext_rd, tprev_rd, head_rd, tail_rd;

  logic  tchan_we, tnext_we, tprev_we, head_we, tail_we;
  task_t tchan_waddr, tnext_waddr, tprev_waddr;
  chan_t head_waddr, tail_waddr;
  chan_t tchan_wdata;
  task_t tnext_wdata, tprev_wdata, head_wdata, tail_wdata;

  // First-read data held for the unlink step
  chan_t tchan_q;
  task_t tnext_q, tprev_q, head_q, tail_q;

  // Result registers
  logic    done_q, done_d;
  status_e status_q, status_d;
  task_t   tout_q, tout_d;
  logic    isq_q, isq_d;
  chan_t   chout_q, chout_d;

  // Unlink operands: pop takes the head of the named channel, remove takes
  // the named task out of the channel it was found in.
  logic  is_pop;
  chan_t u_chan;
  task_t u_task, u_head, u_tail, u_next, u_prev;
  logic  u_is_head, u_is_tail;

  assign is_pop    = (op_q == OP_POP);
  assign u_chan    = is_pop ? c_q      : tchan_q;
  assign u_task    = is_pop ? head_q   : t_q;
  assign u_head    = is_pop ? head_q   : head_rd;
  assign u_tail    = is_pop ? tail_q   : tail_rd;
  assign u_next    = is_pop ? tnext_rd : tnext_q;
  assign u_prev    = is_pop ? tprev_rd : tprev_q;
  assign u_is_head = (u_head == u_task);
  assign u_is_tail = (u_tail == u_task);

  always_comb begin
    state_d     = state_q;
    queued_d    = queued_q;
    nonempty_d  = nonempty_q;
    task_raddr  = task_index_i;
    chan_raddr  = channel_index_i;
    tchan_we    = 1'b0;
    tnext_we    = 1'b0;
    tprev_we    = 1'b0;
    head_we     = 1'b0;
    tail_we     = 1'b0;
    tchan_waddr = t_q;
    tnext_waddr = t_q;
    tprev_waddr = t_q;
    head_waddr  = c_q;
    tail_waddr  = c_q;
    tchan_wdata = c_q;
    tnext_wdata = t_q;
    tprev_wdata = t_q;
    head_wdata  = t_q;
    tail_wdata  = t_q;
    done_d      = 1'b0;
    status_d    = status_q;
    tout_d      = tout_q;
    isq_d       = isq_q;
    chout_d     = chout_q;

    case (state_q)
      S_IDLE: begin
        // RAM reads at the request's task and channel go out with the transfer
        if (start_i) begin
          state_d = S_RD1;
        end
      end

      S_RD1: begin
        tout_d = t_q;
        case (op_q)
          OP_SCHEDULE: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
            isq_d   = 1'b1;
            if (queued_q[t_q]) begin
              status_d = ST_ALREADY;
              chout_d  = tchan_rd;
            end else begin
              status_d = ST_OK;
              chout_d  = c_q;
              if (nonempty_q[c_q]) begin
                // Link behind the current tail
                tnext_we    = 1'b1;
                tnext_waddr = tail_rd;
                tnext_wdata = t_q;
                tprev_we    = 1'b1;
                tprev_waddr = t_q;
                tprev_wdata = tail_rd;
              end else begin
                head_we       = 1'b1;
                head_waddr    = c_q;
                head_wdata    = t_q;
                nonempty_d[c_q] = 1'b1;
              end
              tail_we       = 1'b1;
              tail_waddr    = c_q;
              tail_wdata    = t_q;
              tchan_we      = 1'b1;
              tchan_waddr   = t_q;
              tchan_wdata   = c_q;
              queued_d[t_q] = 1'b1;
            end
          end
          OP_POP: begin
            if (nonempty_q[c_q]) begin
              // Fetch the head's links
              task_raddr = head_rd;
              state_d    = S_RD2;
            end else begin
              done_d   = 1'b1;
              state_d  = S_IDLE;
              status_d = ST_EMPTY;
              isq_d    = queued_q[t_q];
              chout_d  = queued_q[t_q] ? tchan_rd : '0;
            end
          end
          OP_REMOVE: begin
            if (queued_q[t_q]) begin
              // Fetch head and tail of the task's channel
              chan_raddr = tchan_rd;
              state_d    = S_RD2;
            end else begin
              done_d   = 1'b1;
              state_d  = S_IDLE;
              status_d = ST_NOT_QUEUED;
              isq_d    = 1'b0;
              chout_d  = '0;
            end
          end
          default: begin
            done_d   = 1'b1;
            state_d  = S_IDLE;
            status_d = queued_q[t_q] ? ST_OK : ST_NOT_QUEUED;
            isq_d    = queued_q[t_q];
            chout_d  = queued_q[t_q] ? tchan_rd : '0;
          end
        endcase
      end

      S_RD2: begin
        // Unlink u_task from u_chan
        if (u_is_head && u_is_tail) begin
          nonempty_d[u_chan] = 1'b0;
        end else begin
          if (u_is_head) begin
            head_we    = 1'b1;
            head_waddr = u_chan;
            head_wdata = u_next;
          end else begin
            tnext_we    = 1'b1;
            tnext_waddr = u_prev;
            tnext_wdata = u_next;
          end
          if (u_is_tail) begin
            tail_we    = 1'b1;
            tail_waddr = u_chan;
            tail_wdata = u_prev;
          end else begin
            tprev_we    = 1'b1;
            tprev_waddr = u_next;
            tprev_wdata = u_prev;
          end
        end
        queued_d[u_task] = 1'b0;
        done_d   = 1'b1;
        state_d  = S_IDLE;
        status_d = ST_OK;
        tout_d   = u_task;
        isq_d    = 1'b0;
        chout_d  = '0;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      queued_q   <= '0;
      nonempty_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      queued_q   <= queued_d;
      nonempty_q <= nonempty_d;
      done_q     <= done_d;
    end
  end

  // Payload registers: request, first-read data and result
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q <= opcode_i;
      t_q  <= task_index_i;
      c_q  <= channel_index_i;
    end
    if (state_q == S_RD1) begin
      tchan_q <= tchan_rd;
      tnext_q <= tnext_rd;
      tprev_q <= tprev_rd;
      head_q  <= head_rd;
      tail_q  <= tail_rd;
    end
    status_q <= status_d;
    tout_q   <= tout_d;
    isq_q    <= isq_d;
    chout_q  <= chout_d;
  end

  mctq_ram #(.WIDTH(CHAN_W), .DEPTH(NUM_TASKS)) u_tchan_ram (
    .clk_i   (clk_i),
    .we_i    (tchan_we),
    .waddr_i (tchan_waddr),
    .wdata_i (tchan_wdata),
    .raddr_i (task_raddr),
    .rdata_o (tchan_rd)
  );

  mctq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_tnext_ram (
    .clk_i   (clk_i),
    .we_i    (tnext_we),
    .waddr_i (tnext_waddr),
    .wdata_i (tnext_wdata),
    .raddr_i (task_raddr),
    .rdata_o (tnext_rd)
  );

  mctq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_tprev_ram (
    .clk_i   (clk_i),
    .we_i    (tprev_we),
    .waddr_i (tprev_waddr),
    .wdata_i (tprev_wdata),
    .raddr_i (task_raddr),
    .rdata_o (tprev_rd)
  );

  mctq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_CHANNELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (chan_raddr),
    .rdata_o (head_rd)
  );

  mctq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_CHANNELS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (tail_waddr),
    .wdata_i (tail_wdata),
    .raddr_i (chan_raddr),
    .rdata_o (tail_rd)
  );

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign task_out_o    = tout_q;
  assign is_queued_o   = isq_q;
  assign channel_out_o = chout_q;

endmodule

[tb/sv/multi_channel_task_queue_unit_tb.sv]
// Self-checking testbench of the multi-channel task queue unit.
module multi_channel_task_queue_unit_tb;
  import mctq_pkg::*;

  // One reply of the unit, as the shadow of the channel lists predicts it.
  typedef struct {
    status_e status;
    task_t   task_out;
    logic    is_queued;
    chan_t   channel_out;
  } reply_t;

  // Shadow copy of the linked lists: predicts each reply on acceptance of a
  // request and holds the predictions until the unit answers.
  class channel_list_shadow;
    bit          on_list   [NUM_TASKS];
    chan_t       owner     [NUM_TASKS];
    task_t       succ      [NUM_TASKS];
    task_t       pred      [NUM_TASKS];
    bit          occupied  [NUM_CHANNELS];
    task_t       head      [NUM_CHANNELS];
    task_t       tail      [NUM_CHANNELS];
    reply_t      awaited_replies[$];
    int unsigned errors;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        on_list[i] = 1'b0;
        owner[i]   = '0;
        succ[i]    = '0;
        pred[i]    = '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        occupied[i] = 1'b0;
        head[i]     = '0;
        tail[i]     = '0;
      end
      errors = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return awaited_replies.size();
    endfunction

    // Unlink a queued task from wherever it sits in its channel.
    function void detach(input task_t t);
      chan_t c;
      bit    at_head, at_tail;
      task_t nx, pv;
      c       = owner[t];
      at_head = (head[c] == t);
      at_tail = (tail[c] == t);
      nx      = succ[t];
      pv      = pred[t];
      if (at_head && at_tail) begin
        occupied[c] = 1'b0;
      end else begin
        if (at_head) head[c] = nx;
        else         succ[pv] = nx;
        if (at_tail) tail[c] = pv;
        else         pred[nx] = pv;
      end
      on_list[t] = 1'b0;
    endfunction

    // Apply one accepted request to the shadow lists and queue its reply.
    function void note_request(input op_e op, input task_t t, input chan_t c);
      reply_t r;
      task_t  h;
      r.status      = ST_OK;
      r.task_out    = t;
      r.is_queued   = 1'b0;
      r.channel_out = '0;
      case (op)
        OP_SCHEDULE: begin
          if (on_list[t]) begin
            r.status = ST_ALREADY;
          end else begin
            if (occupied[c]) begin
              succ[tail[c]] = t;
              pred[t]       = tail[c];
            end else begin
              head[c]     = t;
              occupied[c] = 1'b1;
            end
            tail[c]    = t;
            on_list[t] = 1'b1;
            owner[t]   = c;
          end
        end
        OP_POP: begin
          if (occupied[c]) begin
            h = head[c];
            detach(h);
            r.task_out = h;
          end else begin
            r.status = ST_EMPTY;
          end
        end
        OP_REMOVE: begin
          if (on_list[t]) detach(t);
          else            r.status = ST_NOT_QUEUED;
        end
        default: begin
          if (!on_list[t]) r.status = ST_NOT_QUEUED;
        end
      endcase
      if (on_list[r.task_out]) begin
        r.is_queued   = 1'b1;
        r.channel_out = owner[r.task_out];
      end
      awaited_replies.push_back(r);
    endfunction

    // Compare a reply of the unit with the oldest prediction.
    task check_reply(input reply_t got);
      reply_t want;
      if (awaited_replies.size() == 0) begin
        report($sformatf("unexpected reply status=%0d task=%0d queued=%0b chan=%0d",
                         got.status, got.task_out, got.is_queued, got.channel_out));
      end else begin
        want = awaited_replies.pop_front();
        if (got.status !== want.status || got.task_out !== want.task_out ||
            got.is_queued !== want.is_queued || got.channel_out !== want.channel_out)
          report($sformatf({"reply status=%0d task=%0d queued=%0b chan=%0d, ",
                            "want status=%0d task=%0d queued=%0b chan=%0d"},
                           got.status, got.task_out, got.is_queued, got.channel_out,
                           want.status, want.task_out, want.is_queued,
                           want.channel_out));
      end
    endtask
  endclass

  logic    clk_i           = 1'b0;
  logic    rst_ni          = 1'b0;
  logic    start_i         = 1'b0;
  op_e     opcode_i        = OP_QUERY;
  task_t   task_index_i    = '0;
  chan_t   channel_index_i = '0;
  logic    busy_o;
  logic    done_o;
  status_e status_o;
  task_t   task_out_o;
  logic    is_queued_o;
  chan_t   channel_out_o;

  channel_list_shadow shadow = new();

  multi_channel_task_queue_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .task_index_i    (task_index_i),
    .channel_index_i (channel_index_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .task_out_o      (task_out_o),
    .is_queued_o     (is_queued_o),
    .channel_out_o   (channel_out_o)
  );

  always #5 clk_i = ~clk_i;

  // Observe both sides at each rising edge. Inputs are driven by nonblocking
  // assignment at the same edge, so the values seen here are the settled ones
  // from the cycle just ended. Check the reply before noting a new transfer:
  // a reply never belongs to the request taken at the same edge.
  always @(posedge clk_i) begin
    reply_t seen;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        seen.status      = status_o;
        seen.task_out    = task_out_o;
        seen.is_queued   = is_queued_o;
        seen.channel_out = channel_out_o;
        shadow.check_reply(seen);
      end
      if (start_i === 1'b1 && busy_o === 1'b0)
        shadow.note_request(opcode_i, task_index_i, channel_index_i);
    end
  end

  // Present one request and hold it until the unit takes it. On return the
  // transfer has just happened, and start_i is still high: the caller either
  // presents the next request at once or drops start_i to idle.
  task automatic issue(input op_e op, input int unsigned t, input int unsigned c);
    start_i         <= 1'b1;
    opcode_i        <= op;
    task_index_i    <= task_t'(t);
    channel_index_i <= chan_t'(c);
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Drop start_i for a number of cycles and put noise on the request fields,
  // which the unit must ignore while start_i is low.
  task automatic pause(input int unsigned cycles);
    if (cycles != 0) begin
      start_i         <= 1'b0;
      opcode_i        <= op_e'($urandom_range(0, 3));
      task_index_i    <= task_t'($urandom_range(0, NUM_TASKS - 1));
      channel_index_i <= chan_t'($urandom_range(0, NUM_CHANNELS - 1));
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Weighted choice of operation: schedules dominate so that lists grow deep,
  // pops and removes drain them again.
  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      return OP_SCHEDULE;
    else if (r < 65) return OP_POP;
    else if (r < 85) return OP_REMOVE;
    else             return OP_QUERY;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned focus;
    int unsigned chan;
    int unsigned spin;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: requests on an empty pool, a schedule of a task already
    // queued, removal from the middle and from the tail, pops of a head with
    // and without a successor, a pop of an empty channel naming a queued task,
    // and the extremes of every field.
    issue(OP_QUERY,    0,  0);
    issue(OP_REMOVE,   15, 7);
    issue(OP_POP,      0,  7);
    issue(OP_POP,      15, 0);
    issue(OP_SCHEDULE, 0,  0);
    issue(OP_SCHEDULE, 15, 7);
    issue(OP_SCHEDULE, 0,  3);
    issue(OP_QUERY,    0,  5);
    issue(OP_QUERY,    15, 2);
    issue(OP_SCHEDULE, 5,  0);
    issue(OP_SCHEDULE, 9,  0);
    issue(OP_REMOVE,   5,  6);
    issue(OP_REMOVE,   9,  1);
    issue(OP_SCHEDULE, 10, 0);
    issue(OP_POP,      3,  0);
    issue(OP_POP,      3,  0);
    issue(OP_POP,      3,  0);
    issue(OP_POP,      0,  7);
    issue(OP_SCHEDULE, 3,  7);
    issue(OP_REMOVE,   3,  4);
    issue(OP_QUERY,    3,  7);
    issue(OP_SCHEDULE, 6,  2);
    issue(OP_POP,      6,  5);
    issue(OP_REMOVE,   6,  2);
    pause(3);

    // Random part: bursts of back-to-back transfers with random gaps, most
    // traffic aimed at one focus channel so that long lists build up and
    // removals hit every position in them.
    sent  = 0;
    focus = $urandom_range(0, NUM_CHANNELS - 1);
    while (sent < 850) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 3) == 0) focus = $urandom_range(0, NUM_CHANNELS - 1);
      repeat (burst) begin
        chan = ($urandom_range(0, 9) < 7) ? focus : $urandom_range(0, NUM_CHANNELS - 1);
        issue(pick_op(), $urandom_range(0, NUM_TASKS - 1), chan);
        sent++;
      end
      // Leave a quarter of the bursts without a gap behind them.
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
    end
    start_i <= 1'b0;

    // Drain: wait for outstanding replies, then wait on to catch strays.
    spin = 0;
    while (shadow.pending() != 0 && spin < 200) begin
      @(posedge clk_i);
      spin++;
    end
    repeat (6) @(posedge clk_i);
    if (shadow.pending() != 0)
      shadow.report($sformatf("%0d replies never arrived", shadow.pending()));

    if (shadow.errors == 0) begin
      $display("multi_channel_task_queue_unit: match");
    end else begin
      $display("multi_channel_task_queue_unit: mismatch");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("multi_channel_task_queue_unit: mismatch");
    $finish;
  end

endmodule

[multi_channel_task_queue_unit.f]
rtl/mctq_pkg.sv
rtl/mctq_ram.sv
rtl/multi_channel_task_queue_unit.sv
tb/sv/multi_channel_task_queue_unit_tb.sv
